// ===== rtl/core/bti_pkg.sv =====
// Shared types and codes for the bilinear table interpolator.
// Used by every module under rtl/core except bti_ram; depends on nothing.
`default_nettype none

package bti_pkg;

    // Input item operations
    localparam logic [1:0] OP_LOAD_ANGLE = 2'd0;
    localparam logic [1:0] OP_LOAD_SPEED = 2'd1;
    localparam logic [1:0] OP_LOAD_COEF  = 2'd2;
    localparam logic [1:0] OP_LOOKUP     = 2'd3;

    // Configuration register indexes
    localparam int          CFG_INDEX_WIDTH = 4;
    localparam logic [3:0]  CFG_ANGLE_COUNT = 4'd0;
    localparam logic [3:0]  CFG_SPEED_COUNT = 4'd1;

    // Width of stored breakpoints and table entries (Q16.16)
    localparam int POINT_WIDTH = 32;

    typedef struct packed {
        logic [1:0]         operation;
        logic [5:0]         row_index;
        logic [3:0]         column_index;
        logic signed [31:0] load_value;
        logic signed [31:0] query_angle;
        logic signed [31:0] query_speed;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] interpolated;
        logic               angle_outside;
        logic               speed_outside;
        logic               degenerate;
    } out_item_t;

    // Status of one axis search
    typedef struct packed {
        logic               done;
        logic               outside;
        logic signed [31:0] p_lo;
        logic signed [31:0] p_hi;
    } srch_stat_t;

    // Status of the linear step unit
    typedef struct packed {
        logic done;
        logic deg;
    } lerp_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/bti_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package use.
`default_nettype none

module bti_ram #(
    parameter int  WIDTH = 32,
    parameter int  DEPTH = 64,
    localparam int AW    = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/core/bti_search.sv =====
// Linear segment search over one breakpoint axis held in a RAM.
// Depends on bti_pkg (srch_stat_t); reads the axis RAM through its read port.
`default_nettype none

module bti_search #(
    parameter int  DEPTH = 64,
    localparam int AW    = $clog2(DEPTH),
    localparam int CW    = $clog2(DEPTH + 1)
) (
    input  wire logic               clk,
    input  wire logic               rstn,
    input  wire logic               start,
    input  wire logic [CW-1:0]      count,
    input  wire logic signed [31:0] x,
    output logic                    rd_en,
    output logic [AW-1:0]           rd_addr,
    input  wire logic [31:0]        rd_data,
    output logic [AW-1:0]           seg,
    output bti_pkg::srch_stat_t     stat
);

    logic              issuing_reg, vld_reg, fin_reg, done_reg, found_reg;
    logic [CW-1:0]     issue_reg, vidx_reg, count_reg;
    logic signed [31:0] x_reg, first_reg, second_reg, prev_reg, pen_reg, last_reg;
    logic signed [31:0] flo_reg, fhi_reg, lo_reg, hi_reg;
    logic [AW-1:0]     fseg_reg, seg_reg;
    logic              out_reg;
    logic signed [31:0] pt;
    logic              hit;

    assign pt  = $signed(rd_data);
    assign hit = (vidx_reg != '0) && !found_reg && (prev_reg < x_reg) && (x_reg <= pt);

    // Read sequencing and completion
    always_ff @(posedge clk) begin
        if (!rstn) begin
            issuing_reg <= 1'b0;
            vld_reg     <= 1'b0;
            fin_reg     <= 1'b0;
            done_reg    <= 1'b0;
            found_reg   <= 1'b0;
        end else begin
            vld_reg <= issuing_reg;
            fin_reg <= vld_reg && (vidx_reg == count_reg - 1'b1);
            if (start) begin
                issuing_reg <= 1'b1;
                done_reg    <= 1'b0;
                found_reg   <= 1'b0;
            end else begin
                if (issuing_reg && issue_reg == count_reg - 1'b1) begin
                    issuing_reg <= 1'b0;
                end
                if (vld_reg && hit) begin
                    found_reg <= 1'b1;
                end
                if (fin_reg) begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Scan datapath: track first, second, previous and last points
    always_ff @(posedge clk) begin
        vidx_reg <= issue_reg;
        if (start) begin
            issue_reg <= '0;
            x_reg     <= x;
            count_reg <= count;
        end else if (issuing_reg) begin
            issue_reg <= issue_reg + 1'b1;
        end
        if (vld_reg) begin
            prev_reg <= pt;
            if (vidx_reg == '0) begin
                first_reg <= pt;
            end
            if (vidx_reg == CW'(1)) begin
                second_reg <= pt;
            end
            if (hit) begin
                fseg_reg <= vidx_reg[AW-1:0];
                flo_reg  <= prev_reg;
                fhi_reg  <= pt;
            end
            if (vidx_reg == count_reg - 1'b1) begin
                last_reg <= pt;
                pen_reg  <= prev_reg;
            end
        end
        // Pick the segment once the scan is complete
        if (fin_reg) begin
            if (x_reg <= first_reg) begin
                seg_reg <= AW'(1);
                lo_reg  <= first_reg;
                hi_reg  <= second_reg;
                out_reg <= 1'b1;
            end else if (x_reg >= last_reg) begin
                seg_reg <= AW'(count_reg - 1'b1);
                lo_reg  <= pen_reg;
                hi_reg  <= last_reg;
                out_reg <= 1'b1;
            end else if (found_reg) begin
                seg_reg <= fseg_reg;
                lo_reg  <= flo_reg;
                hi_reg  <= fhi_reg;
                out_reg <= 1'b0;
            end else begin
                seg_reg <= AW'(count_reg - 1'b1);
                lo_reg  <= pen_reg;
                hi_reg  <= last_reg;
                out_reg <= 1'b0;
            end
        end
    end

    assign rd_en        = issuing_reg;
    assign rd_addr      = issue_reg[AW-1:0];
    assign seg          = seg_reg;
    assign stat.done    = done_reg;
    assign stat.outside = out_reg;
    assign stat.p_lo    = lo_reg;
    assign stat.p_hi    = hi_reg;

endmodule

`default_nettype wire

// ===== rtl/core/bti_lerp.sv =====
// Multi-cycle linear step: slope by restoring division, term by byte-serial
// multiply, then saturating add; a zero-width segment skips to the add. Depends on bti_pkg (lerp_stat_t).
`default_nettype none

module bti_lerp #(
    parameter int  DW = 32,
    parameter int  VW = 32,
    localparam int QW   = DW + 16,
    localparam int PW   = QW + 32,
    localparam int TW   = PW - 16,
    localparam int SW   = 66,
    localparam int CNTW = $clog2(QW + 1)
) (
    input  wire logic                clk,
    input  wire logic                rstn,
    input  wire logic                start,
    input  wire logic signed [DW-1:0] d0,
    input  wire logic signed [DW-1:0] d1,
    input  wire logic signed [31:0]  p0,
    input  wire logic signed [31:0]  p1,
    input  wire logic signed [31:0]  x,
    output logic signed [DW-1:0]     res,
    output bti_pkg::lerp_stat_t      stat
);

    localparam logic [2:0] L_IDLE = 3'd0;
    localparam logic [2:0] L_DIV  = 3'd1;
    localparam logic [2:0] L_MUL  = 3'd2;
    localparam logic [2:0] L_TERM = 3'd3;
    localparam logic [2:0] L_SUM  = 3'd4;

    localparam logic signed [SW-1:0] VMAX_S   = (SW'(1) << (VW - 1)) - SW'(1);
    localparam logic signed [SW-1:0] VMIN_S   = ~VMAX_S;
    localparam logic [TW-1:0]        TQ_LIMIT = TW'(1) << 62;

    logic [2:0]          state_reg;
    logic                done_reg, deg_reg;
    logic [CNTW-1:0]     cnt_reg;
    logic signed [DW-1:0] d0_reg, res_reg;
    logic [QW-1:0]       num_reg;
    logic [31:0]         rem_reg, wm_reg, xm_reg;
    logic [PW-1:0]       acc_reg;
    logic signed [63:0]  term_reg;
    logic                neg_reg, zero_reg, dpos_reg, dneg_reg;

    logic signed [DW:0]  diff_w;
    logic signed [32:0]  w_w, dx_w;
    logic [DW-1:0]       dm_w;
    logic [31:0]         wm_w, xm_w;
    logic                dnz_w, xnz_w;
    logic [32:0]         rem_sh, rem_sub;
    logic                ge_w;
    logic [QW+7:0]       mprod;
    logic [TW-1:0]       tq_full;
    logic [62:0]         tq_cap, tq1;
    logic signed [63:0]  term_w;
    logic signed [SW-1:0] sum_w, sat_w;
    logic                sat_flag;

    // Operand preparation at start
    assign diff_w = {d1[DW-1], d1} - {d0[DW-1], d0};
    assign w_w    = {p1[31], p1} - {p0[31], p0};
    assign dx_w   = {x[31], x} - {p0[31], p0};
    assign dm_w   = diff_w[DW] ? DW'(-diff_w) : diff_w[DW-1:0];
    assign wm_w   = w_w[32] ? 32'(-w_w) : w_w[31:0];
    assign xm_w   = dx_w[32] ? 32'(-dx_w) : dx_w[31:0];
    assign dnz_w  = (diff_w != '0);
    assign xnz_w  = (dx_w != '0);

    // One quotient bit per cycle
    assign rem_sh  = {rem_reg, num_reg[QW-1]};
    assign ge_w    = (rem_sh >= {1'b0, wm_reg});
    assign rem_sub = rem_sh - {1'b0, wm_reg};

    // Slope times one byte of |dx|
    assign mprod = num_reg * xm_reg[31:24];

    // Floor-rounded, capped term
    assign tq_full = acc_reg[PW-1:16];
    assign tq_cap  = (tq_full > TQ_LIMIT) ? 63'(TQ_LIMIT) : tq_full[62:0];
    assign tq1     = tq_cap + 63'(neg_reg && (acc_reg[15:0] != '0));
    assign term_w  = neg_reg ? -$signed({1'b0, tq1}) : $signed({1'b0, tq1});

    // Saturating sum
    assign sum_w    = SW'(d0_reg) + SW'(term_reg);
    assign sat_flag = (sum_w > VMAX_S) || (sum_w < VMIN_S);
    assign sat_w    = (sum_w > VMAX_S) ? VMAX_S : ((sum_w < VMIN_S) ? VMIN_S : sum_w);

    // Control
    always_ff @(posedge clk) begin
        if (!rstn) begin
            state_reg <= L_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            case (state_reg)
                L_IDLE: begin
                    if (start) begin
                        state_reg <= (w_w == '0) ? L_SUM : L_DIV;
                    end
                end
                L_DIV: begin
                    if (cnt_reg == CNTW'(1)) begin
                        state_reg <= L_MUL;
                    end
                end
                L_MUL: begin
                    if (cnt_reg == CNTW'(1)) begin
                        state_reg <= L_TERM;
                    end
                end
                L_TERM: begin
                    state_reg <= L_SUM;
                end
                L_SUM: begin
                    state_reg <= L_IDLE;
                    done_reg  <= 1'b1;
                end
                default: begin
                    state_reg <= L_IDLE;
                end
            endcase
        end
    end

    // Datapath
    always_ff @(posedge clk) begin
        case (state_reg)
            L_IDLE: begin
                if (start) begin
                    d0_reg   <= d0;
                    num_reg  <= {dm_w, 16'b0};
                    rem_reg  <= '0;
                    wm_reg   <= wm_w;
                    xm_reg   <= xm_w;
                    cnt_reg  <= CNTW'(QW);
                    neg_reg  <= (diff_w[DW] ^ w_w[32]) ^ dx_w[32];
                    zero_reg <= (w_w == '0);
                    dpos_reg <= dnz_w && xnz_w && (diff_w[DW] == dx_w[32]);
                    dneg_reg <= dnz_w && xnz_w && (diff_w[DW] != dx_w[32]);
                    term_reg <= '0;
                end
            end
            L_DIV: begin
                rem_reg <= ge_w ? rem_sub[31:0] : rem_sh[31:0];
                num_reg <= {num_reg[QW-2:0], ge_w};
                if (cnt_reg == CNTW'(1)) begin
                    cnt_reg <= CNTW'(4);
                    acc_reg <= '0;
                end else begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
            L_MUL: begin
                acc_reg <= {acc_reg[PW-9:0], 8'b0} + PW'(mprod);
                xm_reg  <= {xm_reg[23:0], 8'b0};
                cnt_reg <= cnt_reg - 1'b1;
            end
            L_TERM: begin
                term_reg <= term_w;
            end
            L_SUM: begin
                if (zero_reg) begin
                    deg_reg <= 1'b1;
                    if (dpos_reg) begin
                        res_reg <= DW'(VMAX_S);
                    end else if (dneg_reg) begin
                        res_reg <= DW'(VMIN_S);
                    end else begin
                        res_reg <= DW'(sat_w);
                    end
                end else begin
                    deg_reg <= sat_flag;
                    res_reg <= DW'(sat_w);
                end
            end
            default: begin
            end
        endcase
    end

    assign res       = res_reg;
    assign stat.done = done_reg;
    assign stat.deg  = deg_reg;

endmodule

`default_nettype wire

// ===== rtl/core/bilinear_table_interpolator_unit.sv =====
// Bilinear interpolator over a 2-D Q16.16 coefficient table with two breakpoint axes.
// Depends on bti_pkg, bti_ram, bti_search and bti_lerp.
//
// Usage:
//   s_valid/s_ready/s_data take one item. Loads (angle point, speed point, table
//   entry) are written into RAM in the cycle of transfer; s_ready stays high.
//   A lookup runs both axis searches in parallel (one RAM read per cycle),
//   reads four table entries, then runs three linear steps on one shared
//   unit. Each step finds its slope by bit-serial division, producing
//   max(VALUE_WIDTH, 32) + 16 quotient bits; a zero-width segment skips the
//   division and the multiply. m_valid rises in the cycle in which s_ready
//   returns high, so the next item can be taken in that same cycle.
//   s_ready is low while a lookup is in progress; one item at a time.
//   The result sits in an output register on m_valid/m_ready; a new item is
//   taken while it waits, and a lookup finishing into a full register holds
//   until the receiver takes the waiting transfer.
//   cfg_valid/cfg_ready write angle_count (index 0) or speed_count (index 1),
//   clamped to 2..axis maximum; cfg_ready is always high.
//   Reset (aresetn low, synchronous) sets both counts to 2 and empties the
//   output register. RAM contents are undefined until written.
`default_nettype none

module bilinear_table_interpolator_unit #(
    parameter int MAX_ANGLE_POINTS = 64,
    parameter int MAX_SPEED_POINTS = 16,
    parameter int VALUE_WIDTH      = 32
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   s_valid,
    output logic                                        s_ready,
    input  wire bti_pkg::in_item_t                      s_data,
    output logic                                        m_valid,
    input  wire logic                                   m_ready,
    output bti_pkg::out_item_t                          m_data,
    input  wire logic                                   cfg_valid,
    output logic                                        cfg_ready,
    input  wire logic [bti_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
    input  wire logic [31:0]                            cfg_data
);

    localparam int DW  = (VALUE_WIDTH > 32) ? VALUE_WIDTH : 32;
    localparam int AAW = $clog2(MAX_ANGLE_POINTS);
    localparam int SAW = $clog2(MAX_SPEED_POINTS);
    localparam int ACW = $clog2(MAX_ANGLE_POINTS + 1);
    localparam int SCW = $clog2(MAX_SPEED_POINTS + 1);
    localparam int CAW = $clog2(MAX_ANGLE_POINTS * MAX_SPEED_POINTS);
    localparam logic [CAW-1:0] S_STRIDE = CAW'(MAX_SPEED_POINTS);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SEARCH = 3'd1;
    localparam logic [2:0] ST_COEF   = 3'd2;
    localparam logic [2:0] ST_LGO    = 3'd3;
    localparam logic [2:0] ST_LWAIT  = 3'd4;
    localparam logic [2:0] ST_OUT    = 3'd5;

    logic [2:0]           state_reg;
    logic [ACW-1:0]       a_count_reg;
    logic [SCW-1:0]       s_count_reg;
    logic [2:0]           c_cnt_reg;
    logic [1:0]           sel_reg;
    logic                 deg_reg;
    logic                 m_valid_reg;
    bti_pkg::out_item_t   out_reg;
    logic signed [31:0]   qa_reg, qs_reg;
    logic signed [31:0]   coef_reg [4];
    logic signed [DW-1:0] low_reg, high_reg;

    logic                 accept, lookup_start, in_op_ok;
    logic                 a_we, s_we, c_we;
    logic                 a_re, s_re, c_re;
    logic [AAW-1:0]       a_raddr, a_seg;
    logic [SAW-1:0]       s_raddr, s_seg;
    logic [31:0]          a_rdata, s_rdata, c_rdata;
    logic [CAW-1:0]       c_waddr, c_raddr;
    logic [AAW-1:0]       row_sel;
    logic [SAW-1:0]       col_sel;
    bti_pkg::srch_stat_t  a_stat, s_stat;
    bti_pkg::lerp_stat_t  l_stat;
    logic                 lerp_start;
    logic signed [DW-1:0] l_d0, l_d1, l_res;
    logic signed [31:0]   l_p0, l_p1, l_x;
    logic                 out_free;

    // Input transfer and load decode
    assign s_ready      = (state_reg == ST_IDLE);
    assign accept       = s_valid && s_ready;
    assign lookup_start = accept && (s_data.operation == bti_pkg::OP_LOOKUP);
    assign in_op_ok     = (32'(s_data.row_index) < MAX_ANGLE_POINTS);
    assign a_we = accept && (s_data.operation == bti_pkg::OP_LOAD_ANGLE) && in_op_ok;
    assign s_we = accept && (s_data.operation == bti_pkg::OP_LOAD_SPEED)
                  && (32'(s_data.column_index) < MAX_SPEED_POINTS);
    assign c_we = accept && (s_data.operation == bti_pkg::OP_LOAD_COEF) && in_op_ok
                  && (32'(s_data.column_index) < MAX_SPEED_POINTS);
    assign c_waddr = CAW'(s_data.row_index) * S_STRIDE + CAW'(s_data.column_index);

    // Breakpoint and table memories
    bti_ram #(.WIDTH(bti_pkg::POINT_WIDTH), .DEPTH(MAX_ANGLE_POINTS)) u_angle_ram (
        .clk(aclk), .we(a_we), .waddr(AAW'(s_data.row_index)), .wdata(s_data.load_value),
        .re(a_re), .raddr(a_raddr), .rdata(a_rdata)
    );

    bti_ram #(.WIDTH(bti_pkg::POINT_WIDTH), .DEPTH(MAX_SPEED_POINTS)) u_speed_ram (
        .clk(aclk), .we(s_we), .waddr(SAW'(s_data.column_index)),
        .wdata(s_data.load_value), .re(s_re), .raddr(s_raddr), .rdata(s_rdata)
    );

    bti_ram #(.WIDTH(bti_pkg::POINT_WIDTH), .DEPTH(MAX_ANGLE_POINTS * MAX_SPEED_POINTS))
        u_coef_ram (
        .clk(aclk), .we(c_we), .waddr(c_waddr), .wdata(s_data.load_value),
        .re(c_re), .raddr(c_raddr), .rdata(c_rdata)
    );

    // Axis searches run side by side
    bti_search #(.DEPTH(MAX_ANGLE_POINTS)) u_angle_search (
        .clk(aclk), .rstn(aresetn), .start(lookup_start), .count(a_count_reg),
        .x(s_data.query_angle), .rd_en(a_re), .rd_addr(a_raddr), .rd_data(a_rdata),
        .seg(a_seg), .stat(a_stat)
    );

    bti_search #(.DEPTH(MAX_SPEED_POINTS)) u_speed_search (
        .clk(aclk), .rstn(aresetn), .start(lookup_start), .count(s_count_reg),
        .x(s_data.query_speed), .rd_en(s_re), .rd_addr(s_raddr), .rd_data(s_rdata),
        .seg(s_seg), .stat(s_stat)
    );

    // Corner reads: (i-1,j-1), (i-1,j), (i,j-1), (i,j)
    assign row_sel = c_cnt_reg[1] ? a_seg : a_seg - 1'b1;
    assign col_sel = c_cnt_reg[0] ? s_seg : s_seg - 1'b1;
    assign c_raddr = CAW'(row_sel) * S_STRIDE + CAW'(col_sel);
    assign c_re    = (state_reg == ST_COEF) && !c_cnt_reg[2];

    // Shared linear step: two speed steps, then the angle step
    always_comb begin
        if (sel_reg == 2'd2) begin
            l_d0 = low_reg;
            l_d1 = high_reg;
            l_p0 = $signed(a_stat.p_lo);
            l_p1 = $signed(a_stat.p_hi);
            l_x  = qa_reg;
        end else begin
            l_d0 = (sel_reg == 2'd0) ? DW'(coef_reg[0]) : DW'(coef_reg[2]);
            l_d1 = (sel_reg == 2'd0) ? DW'(coef_reg[1]) : DW'(coef_reg[3]);
            l_p0 = $signed(s_stat.p_lo);
            l_p1 = $signed(s_stat.p_hi);
            l_x  = qs_reg;
        end
    end

    assign lerp_start = (state_reg == ST_LGO);

    bti_lerp #(.DW(DW), .VW(VALUE_WIDTH)) u_lerp (
        .clk(aclk), .rstn(aresetn), .start(lerp_start), .d0(l_d0), .d1(l_d1),
        .p0(l_p0), .p1(l_p1), .x(l_x), .res(l_res), .stat(l_stat)
    );

    assign out_free = !m_valid_reg || m_ready;

    // Sequencer and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            a_count_reg <= ACW'(2);
            s_count_reg <= SCW'(2);
            m_valid_reg <= 1'b0;
            c_cnt_reg   <= '0;
            sel_reg     <= '0;
        end else begin
            if (cfg_valid) begin
                if (cfg_index == bti_pkg::CFG_ANGLE_COUNT) begin
                    if (cfg_data[6:0] < 7'd2) begin
                        a_count_reg <= ACW'(2);
                    end else if (32'(cfg_data[6:0]) > MAX_ANGLE_POINTS) begin
                        a_count_reg <= ACW'(MAX_ANGLE_POINTS);
                    end else begin
                        a_count_reg <= ACW'(cfg_data[6:0]);
                    end
                end else if (cfg_index == bti_pkg::CFG_SPEED_COUNT) begin
                    if (cfg_data[4:0] < 5'd2) begin
                        s_count_reg <= SCW'(2);
                    end else if (32'(cfg_data[4:0]) > MAX_SPEED_POINTS) begin
                        s_count_reg <= SCW'(MAX_SPEED_POINTS);
                    end else begin
                        s_count_reg <= SCW'(cfg_data[4:0]);
                    end
                end
            end
            // Output register: filled by a finished lookup, emptied on transfer
            if (state_reg == ST_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (lookup_start) begin
                        state_reg <= ST_SEARCH;
                    end
                end
                ST_SEARCH: begin
                    if (a_stat.done && s_stat.done) begin
                        state_reg <= ST_COEF;
                        c_cnt_reg <= '0;
                    end
                end
                ST_COEF: begin
                    c_cnt_reg <= c_cnt_reg + 1'b1;
                    if (c_cnt_reg == 3'd4) begin
                        state_reg <= ST_LGO;
                        sel_reg   <= '0;
                    end
                end
                ST_LGO: begin
                    state_reg <= ST_LWAIT;
                end
                ST_LWAIT: begin
                    if (l_stat.done) begin
                        sel_reg   <= sel_reg + 1'b1;
                        state_reg <= (sel_reg == 2'd2) ? ST_OUT : ST_LGO;
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Lookup datapath registers
    always_ff @(posedge aclk) begin
        if (lookup_start) begin
            qa_reg  <= s_data.query_angle;
            qs_reg  <= s_data.query_speed;
        end
        if (state_reg == ST_COEF && c_cnt_reg != 3'd0) begin
            coef_reg[c_cnt_reg[1:0] - 2'd1] <= $signed(c_rdata);
        end
        if (state_reg == ST_LGO && sel_reg == 2'd0) begin
            deg_reg <= 1'b0;
        end else if (state_reg == ST_LWAIT && l_stat.done) begin
            deg_reg <= deg_reg | l_stat.deg;
            if (sel_reg == 2'd0) begin
                low_reg <= l_res;
            end else if (sel_reg == 2'd1) begin
                high_reg <= l_res;
            end
        end
        if (state_reg == ST_OUT && out_free) begin
            out_reg.interpolated  <= l_res[31:0];
            out_reg.angle_outside <= a_stat.outside;
            out_reg.speed_outside <= s_stat.outside;
            out_reg.degenerate    <= deg_reg;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_data    = out_reg;
    assign cfg_ready = 1'b1;

    // Both searches finish before the table is read
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_COEF) |-> (a_stat.done && s_stat.done))
        else $error("table read started before axis searches completed");

    // The step unit only reports while the sequencer waits for it
    assert property (@(posedge aclk) disable iff (!aresetn)
        l_stat.done |-> (state_reg == ST_LWAIT))
        else $error("linear step finished outside of wait state");

    // Chosen angle segment lies inside the axis in use
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SEARCH && a_stat.done) |->
        (a_seg != '0 && ACW'(a_seg) < a_count_reg))
        else $error("angle segment out of range");

    // A finished lookup never overwrites an untaken result
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> m_valid_reg && $stable(out_reg))
        else $error("pending result lost");

endmodule

`default_nettype wire
